// ----- design/tlef_pkg.sv -----
// Package with the types and byte codes of the terminal log escape filter.
`timescale 1ns / 1ps

package tlef_pkg;

    typedef enum logic [1:0] {
        ESC_NORMAL = 2'd0,
        ESC_AFTER  = 2'd1,
        ESC_CSI    = 2'd2,
        ESC_OSC    = 2'd3
    } esc_state_t;

    localparam logic [7:0] CHAR_BEL       = 8'h07;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_ESC       = 8'h1B;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CSI_FINAL_LO   = 8'h40;
    localparam logic [7:0] CSI_FINAL_HI   = 8'h7E;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       line_start;
    } result_t;

endpackage

// ----- design/tlef_intf.sv -----
// Valid/ready channel interfaces for the input, result and configuration streams.
`timescale 1ns / 1ps

interface tlef_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface tlef_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       line_start;

    modport source (output valid, output out_byte, output line_start, input ready);
    modport sink (input valid, input out_byte, input line_start, output ready);
endinterface

interface tlef_cfg_if;
    logic valid;
    logic ready;
    logic filter_mode;

    modport source (output valid, output filter_mode, input ready);
    modport sink (input valid, input filter_mode, output ready);
endinterface

// ----- design/terminal_log_escape_filter.sv -----
// Top level of the terminal log escape filter: parser state, result register and checks.
// Output: a kept byte appears on dout in the cycle after its input transaction.
// Throughput: one byte per cycle; the single result register lets a new byte in
// whenever that register is empty or is being read in the same cycle.
// Reset: rst_n clears the parser to normal text at a line start, with filter mode on
// and the result register empty. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps

module terminal_log_escape_filter (
    input  logic            clk,
    input  logic            rst_n,
    tlef_in_if.sink         din,
    tlef_out_if.source      dout,
    tlef_cfg_if.sink        cfg
);

    logic                 filter_mode_reg;
    logic                 cr_pending_reg, cr_pending_next;
    tlef_pkg::esc_state_t esc_state_reg, esc_state_next;
    logic                 osc_esc_seen_reg, osc_esc_seen_next;
    logic                 at_line_start_reg, at_line_start_next;
    logic                 out_valid_reg;
    tlef_pkg::result_t    result_reg, result_next;
    logic                 emit;
    logic                 in_fire;
    logic [7:0]           ch;

    assign ch        = din.data_byte;
    assign din.ready = !out_valid_reg || dout.ready;
    assign in_fire   = din.valid && din.ready;
    assign cfg.ready = 1'b1;

    assign dout.valid      = out_valid_reg;
    assign dout.out_byte   = result_reg.out_byte;
    assign dout.line_start = result_reg.line_start;

    always_comb
    begin
        cr_pending_next    = cr_pending_reg;
        esc_state_next     = esc_state_reg;
        osc_esc_seen_next  = osc_esc_seen_reg;
        at_line_start_next = at_line_start_reg;
        emit               = 1'b0;
        result_next.out_byte   = ch;
        result_next.line_start = at_line_start_reg;

        if (!filter_mode_reg)
        begin
            emit = 1'b1;
            result_next.line_start = 1'b0;
        end
        else if (cr_pending_reg && ch == tlef_pkg::CHAR_LF)
        begin
            // CR LF collapses to LF, whatever the escape parser is doing.
            cr_pending_next    = 1'b0;
            emit               = 1'b1;
            at_line_start_next = 1'b1;
        end
        else if (ch == tlef_pkg::CHAR_CR)
        begin
            // A lone CR before this one is dropped; this one becomes pending.
            cr_pending_next = 1'b1;
        end
        else
        begin
            cr_pending_next = 1'b0;
            unique case (esc_state_reg)
                tlef_pkg::ESC_NORMAL:
                begin
                    if (ch == tlef_pkg::CHAR_ESC)
                    begin
                        esc_state_next = tlef_pkg::ESC_AFTER;
                    end
                    else
                    begin
                        emit               = 1'b1;
                        at_line_start_next = (ch == tlef_pkg::CHAR_LF);
                    end
                end
                tlef_pkg::ESC_AFTER:
                begin
                    if (ch == tlef_pkg::CHAR_LBRACKET)
                    begin
                        esc_state_next = tlef_pkg::ESC_CSI;
                    end
                    else if (ch == tlef_pkg::CHAR_RBRACKET)
                    begin
                        esc_state_next    = tlef_pkg::ESC_OSC;
                        osc_esc_seen_next = 1'b0;
                    end
                    else
                    begin
                        esc_state_next = tlef_pkg::ESC_NORMAL;
                    end
                end
                tlef_pkg::ESC_CSI:
                begin
                    if (ch >= tlef_pkg::CSI_FINAL_LO && ch <= tlef_pkg::CSI_FINAL_HI)
                    begin
                        esc_state_next = tlef_pkg::ESC_NORMAL;
                    end
                end
                tlef_pkg::ESC_OSC:
                begin
                    if (osc_esc_seen_reg)
                    begin
                        if (ch == tlef_pkg::CHAR_BACKSLASH)
                        begin
                            esc_state_next = tlef_pkg::ESC_NORMAL;
                        end
                        osc_esc_seen_next = 1'b0;
                    end
                    else if (ch == tlef_pkg::CHAR_BEL)
                    begin
                        esc_state_next = tlef_pkg::ESC_NORMAL;
                    end
                    else if (ch == tlef_pkg::CHAR_ESC)
                    begin
                        osc_esc_seen_next = 1'b1;
                    end
                end
                default:
                begin
                    esc_state_next = tlef_pkg::ESC_NORMAL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_mode_reg   <= 1'b1;
            cr_pending_reg    <= 1'b0;
            esc_state_reg     <= tlef_pkg::ESC_NORMAL;
            osc_esc_seen_reg  <= 1'b0;
            at_line_start_reg <= 1'b1;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                filter_mode_reg <= cfg.filter_mode;
            end
            if (in_fire)
            begin
                cr_pending_reg    <= cr_pending_next;
                esc_state_reg     <= esc_state_next;
                osc_esc_seen_reg  <= osc_esc_seen_next;
                at_line_start_reg <= at_line_start_next;
                out_valid_reg     <= emit;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            result_reg <= result_next;
        end
    end

    // Raw mode passes the transaction straight into the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !filter_mode_reg |=>
            dout.valid && dout.out_byte == $past(din.data_byte) && !dout.line_start)
        else $error("raw mode byte not passed through");

    // Inside a sequence, only the LF of a CR LF pair may produce a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && filter_mode_reg && esc_state_reg != tlef_pkg::ESC_NORMAL &&
        din.data_byte != tlef_pkg::CHAR_LF |=> !dout.valid)
        else $error("byte inside an escape sequence was emitted");

    // A CR in filter mode is always held back as pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && filter_mode_reg && din.data_byte == tlef_pkg::CHAR_CR |=>
            cr_pending_reg && !dout.valid)
        else $error("CR not held as pending");

endmodule
